// ===== design/ppod_pkg.sv =====
// Package for the polar point observer distance block.
// Shared constants, the arctangent table and the register indexes.
// No dependencies.
package ppod_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int DEG_UNIT_BITS     = 16;
  localparam int CORDIC_STEPS      = 16;
  localparam int ROOT_BITS         = 32;
  localparam int CFG_INDEX_BITS    = 2;

  // CORDIC start value, 1/K in Q30
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [CFG_INDEX_BITS-1:0] REG_OBSERVER_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OBSERVER_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OBSERVER_Z = 2'd2;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [25:0] atan_deg(input int i);
    logic signed [25:0] t;
    case (i)
      0:       t = 26'sd2949120;
      1:       t = 26'sd1740967;
      2:       t = 26'sd919879;
      3:       t = 26'sd466945;
      4:       t = 26'sd234379;
      5:       t = 26'sd117304;
      6:       t = 26'sd58666;
      7:       t = 26'sd29335;
      8:       t = 26'sd14668;
      9:       t = 26'sd7334;
      10:      t = 26'sd3667;
      11:      t = 26'sd1833;
      12:      t = 26'sd917;
      13:      t = 26'sd458;
      14:      t = 26'sd229;
      15:      t = 26'sd115;
      default: t = 26'sd0;
    endcase
    return t;
  endfunction

endpackage

// ===== design/polar_point_observer_distance.sv =====
// Usage notes:
//   Input stream s_axis_*: one ring-plane point per transaction, radius and
//   azimuth in degrees. Output stream m_axis_*: one distance per point, in
//   the same order, with a saturation flag in tuser.
//   The observer position is set by cfg_we/cfg_index/cfg_data, one register
//   per write; the user sets it only with no point in flight (not enforced).
//   From an accepted input to tvalid on the output, a point passes angle
//   reduction and folding, 16 CORDIC rotation stages, 7 stages of scaling,
//   differences and squares, a 32-stage square root that settles one result
//   bit per stage, and the output register.
//   Throughput is one point per cycle while s_axis_tready is high; every
//   stage is a register stage and the whole pipeline moves on one enable.
//   When the receiver stalls, the output register holds its result and one
//   more finished result lands in a skid register; only then does the
//   pipeline freeze and s_axis_tready fall. Nothing is lost or repeated.
//   Reset (rst, synchronous) clears all valid bits and the observer
//   registers to zero; data in flight is dropped.
//   Depends on ppod_pkg.
module polar_point_observer_distance #(
  parameter int FRAC_BITS = ppod_pkg::FRAC_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // radius[30:0], angle_deg[56:31], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // distance[31:0]
  output logic [0:0]  m_axis_tuser,   // saturated[0]
  input  logic        cfg_we,
  input  logic [ppod_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam longint FULL    = 64'sd360 <<< FRAC_BITS;
  localparam longint RECIP   = (64'sd1 <<< 32) / FULL;
  localparam int     SH_R    = (FRAC_BITS >= ppod_pkg::DEG_UNIT_BITS) ?
                               FRAC_BITS - ppod_pkg::DEG_UNIT_BITS : 0;
  localparam int     SH_L    = (FRAC_BITS < ppod_pkg::DEG_UNIT_BITS) ?
                               ppod_pkg::DEG_UNIT_BITS - FRAC_BITS : 0;
  localparam int     NSTEP   = ppod_pkg::CORDIC_STEPS;
  localparam int     RB      = ppod_pkg::ROOT_BITS;
  localparam logic signed [25:0] HALF    = 26'sd180 <<< ppod_pkg::DEG_UNIT_BITS;
  localparam logic signed [25:0] QUARTER = 26'sd90 <<< ppod_pkg::DEG_UNIT_BITS;

  // observer registers
  logic signed [31:0] observer_x, observer_y, observer_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      observer_x <= '0;
      observer_y <= '0;
      observer_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppod_pkg::REG_OBSERVER_X: observer_x <= cfg_data;
        ppod_pkg::REG_OBSERVER_Y: observer_y <= cfg_data;
        ppod_pkg::REG_OBSERVER_Z: observer_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register plus skid register
  logic        ov, sv;
  logic [31:0] od, sd;
  logic        os, ss;
  logic        ce;

  assign ce            = ~sv;
  assign s_axis_tready = ce;

  // ---------------- angle reduction ----------------
  logic               v1, v2, v3, v4, v5;
  logic [30:0]        r1, r2, r3, r4, r5;
  logic signed [25:0] a1, a2;
  logic signed [44:0] qprod2;
  logic signed [47:0] m3;
  logic signed [25:0] d4, z5;
  logic               nb5, nc5;

  logic signed [12:0] q_est;
  logic signed [47:0] m_fix;
  logic signed [25:0] z_half;

  assign q_est = qprod2[44:32];

  always_comb begin
    if (m3 < 48'sd0)
      m_fix = m3 + 48'(FULL);
    else if (m3 >= 48'(FULL))
      m_fix = m3 - 48'(FULL);
    else
      m_fix = m3;
    z_half = (d4 >= HALF) ? d4 - HALF : d4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (ce) begin
      v1 <= s_axis_tvalid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r1     <= s_axis_tdata[30:0];
      a1     <= s_axis_tdata[56:31];
      r2     <= r1;
      a2     <= a1;
      qprod2 <= a1 * $signed({1'b0, 18'(RECIP)});
      r3     <= r2;
      m3     <= 48'(a2) - 48'(q_est) * 48'(FULL);
      r4     <= r3;
      d4     <= 26'((m_fix >>> SH_R) <<< SH_L);
      r5     <= r4;
      nb5    <= (d4 >= HALF);
      nc5    <= (z_half > QUARTER);
      z5     <= (z_half > QUARTER) ? HALF - z_half : z_half;
    end
  end

  // ---------------- CORDIC rotation stages ----------------
  logic               cv  [0:NSTEP];
  logic signed [32:0] cx  [0:NSTEP];
  logic signed [32:0] cy  [0:NSTEP];
  logic signed [25:0] cz  [0:NSTEP];
  logic [30:0]        cr  [0:NSTEP];
  logic               cnb [0:NSTEP];
  logic               cnc [0:NSTEP];

  assign cv[0]  = v5;
  assign cx[0]  = ppod_pkg::CORDIC_GAIN;
  assign cy[0]  = '0;
  assign cz[0]  = z5;
  assign cr[0]  = r5;
  assign cnb[0] = nb5;
  assign cnc[0] = nc5;

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    logic signed [32:0] xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst)
        cv[i+1] <= 1'b0;
      else if (ce)
        cv[i+1] <= cv[i];
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        cr[i+1]  <= cr[i];
        cnb[i+1] <= cnb[i];
        cnc[i+1] <= cnc[i];
        if (cz[i] >= 26'sd0) begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - ppod_pkg::atan_deg(i);
        end else begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + ppod_pkg::atan_deg(i);
        end
      end
    end
  end

  // ---------------- ring point and differences ----------------
  logic               v6, v7, v8, v9, v10, v11, v12;
  logic [30:0]        r6;
  logic signed [32:0] cos6, sin6;
  logic signed [64:0] pc7, ps7;
  logic signed [33:0] px8, py8;
  logic signed [35:0] dx9, dy9, dz9;
  logic [31:0]        ax10, ay10, az10;
  logic               ov10, ov11, sat12;
  logic [63:0]        sx11, sy11, sz11;
  logic [65:0]        n12;

  logic signed [65:0] pcr, psr;
  logic [35:0]        adx, ady, adz;

  assign pcr = 66'(pc7) + (66'sd1 <<< 29);
  assign psr = 66'(ps7) + (66'sd1 <<< 29);
  assign adx = dx9[35] ? 36'(-dx9) : 36'(dx9);
  assign ady = dy9[35] ? 36'(-dy9) : 36'(dy9);
  assign adz = dz9[35] ? 36'(-dz9) : 36'(dz9);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
      v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0;
    end else if (ce) begin
      v6 <= cv[NSTEP];
      v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v9; v11 <= v10; v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r6   <= cr[NSTEP];
      cos6 <= (cnb[NSTEP] ^ cnc[NSTEP]) ? -cx[NSTEP] : cx[NSTEP];
      sin6 <= cnb[NSTEP] ? -cy[NSTEP] : cy[NSTEP];
      pc7  <= $signed({1'b0, r6}) * cos6;
      ps7  <= $signed({1'b0, r6}) * sin6;
      px8  <= 34'(pcr >>> 30);
      py8  <= 34'(psr >>> 30);
      dx9  <= 36'(px8) - 36'(observer_x);
      dy9  <= 36'(py8) - 36'(observer_y);
      dz9  <= 36'(observer_z);
      ax10 <= adx[31:0];
      ay10 <= ady[31:0];
      az10 <= adz[31:0];
      ov10 <= (|adx[35:32]) | (|ady[35:32]) | (|adz[35:32]);
      sx11 <= ax10 * ax10;
      sy11 <= ay10 * ay10;
      sz11 <= az10 * az10;
      ov11 <= ov10;
      n12  <= 66'(sx11) + 66'(sy11) + 66'(sz11);
      sat12 <= ov11;
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  logic        qv   [0:RB];
  logic [65:0] qrem [0:RB];
  logic [RB-1:0] qroot [0:RB];
  logic        qsat [0:RB];

  assign qv[0]    = v12;
  assign qrem[0]  = {2'b00, n12[63:0]};
  assign qroot[0] = '0;
  assign qsat[0]  = sat12 | (|n12[65:64]);

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int B = RB - 1 - k;
    logic [65:0] trial;
    assign trial = ((66'(qroot[k]) << 1) + (66'd1 << B)) << B;
    always_ff @(posedge clk) begin
      if (rst)
        qv[k+1] <= 1'b0;
      else if (ce)
        qv[k+1] <= qv[k];
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        qsat[k+1] <= qsat[k];
        if (qrem[k] >= trial) begin
          qrem[k+1]  <= qrem[k] - trial;
          qroot[k+1] <= qroot[k] | (RB'(1) << B);
        end else begin
          qrem[k+1]  <= qrem[k];
          qroot[k+1] <= qroot[k];
        end
      end
    end
  end

  logic        fv;
  logic [31:0] fd;
  logic        fs;

  assign fv = qv[RB];
  assign fs = qsat[RB];
  assign fd = fs ? '1 : qroot[RB];

  // ---------------- output and skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || m_axis_tready) begin
      ov <= sv | fv;
      sv <= 1'b0;
    end else if (ce && fv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || m_axis_tready) begin
      od <= sv ? sd : fd;
      os <= sv ? ss : fs;
    end
    if (ov && !m_axis_tready && ce) begin
      sd <= fd;
      ss <= fs;
    end
  end

  assign m_axis_tvalid   = ov;
  assign m_axis_tdata    = od;
  assign m_axis_tuser[0] = os;

  // ---------------- checks ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !m_axis_tready))
    else $error("skid filled without a stalled output");

  a_sat_clamps: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'hFFFF_FFFF))
    else $error("saturated result not clamped");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (z5 >= 26'sd0 && z5 <= QUARTER))
    else $error("folded angle out of first quadrant");

endmodule
